/* sv/sjsc_pkg.sv */
// Shared constants, types and tables for the servo joint slew controller.
// No dependencies; every other file refers to it by scoped names.
package sjsc_pkg;

  localparam int JOINTS             = 5;
  localparam int MIN_COMMAND_JOINTS = 4;

  typedef logic [14:0] cdeg_t;

  localparam cdeg_t       FULL_SCALE  = 15'd18000;
  localparam logic signed [15:0] MRAD_LIMIT = 16'sd1570;
  localparam cdeg_t       SLOW_STEP   = 15'd15;
  localparam cdeg_t       NORMAL_STEP = 15'd50;
  localparam cdeg_t       SETTLE_TOL  = 15'd20;
  localparam logic [9:0]  PULSE_BASE  = 10'd150;

  // floor(x * 900 / 157) is exact as (x * MAP_MULT) >> MAP_SHIFT for x up to 3140.
  localparam logic [22:0] MAP_MULT  = 23'd6010946;
  localparam int          MAP_SHIFT = 20;

  // floor(y / 5) is exact as (y * DIV5_MULT) >> 16 for y below 16384.
  localparam logic [13:0] DIV5_MULT  = 14'd13108;
  localparam int          DIV5_SHIFT = 16;

  localparam cdeg_t STARTUP_POSE [JOINTS] = '{15'd0, 15'd0, 15'd9000, 15'd9000, 15'd9000};

  localparam logic [30:0] LIMITS_RESET [JOINTS] = '{
    31'd786432000, 31'd786432000, 31'd524288000, 31'd786432000, 31'd786432000
  };
  localparam logic [4:0]         INVERT_RESET = 5'd2;
  localparam logic signed [15:0] OFFSET_RESET = -16'sd9000;

  typedef enum logic [2:0] {
    REG_LIMITS0 = 3'd0,
    REG_LIMITS1 = 3'd1,
    REG_LIMITS2 = 3'd2,
    REG_LIMITS3 = 3'd3,
    REG_LIMITS4 = 3'd4,
    REG_INVERT  = 3'd5,
    REG_OFFSET  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic cmd_ok;
    logic tick;
    logic pose_load;
    logic slow;
  } lane_ctl_t;

  typedef struct packed {
    logic slow;
    logic all_settled;
    logic accepted;
    logic pose_loaded;
  } merge_stat_t;

endpackage

/* sv/sjsc_lane.sv */
// One joint lane: maps a commanded angle to a target, steps the position on a tick
// and forms the servo pulse. Depends on sjsc_pkg.
module sjsc_lane (
  input  logic                clk,
  input  sjsc_pkg::lane_ctl_t ctl,
  input  logic                present,
  input  logic signed [15:0]  angle,
  input  logic [30:0]         limits,
  input  logic                invert,
  input  logic signed [15:0]  offset,
  input  sjsc_pkg::cdeg_t     pose,
  output logic                settle_next,
  output logic [9:0]          pulse
);

  logic signed [15:0] mrad;
  logic [11:0]        span;
  logic [34:0]        prod;
  sjsc_pkg::cdeg_t    mapped;

  sjsc_pkg::cdeg_t    lim_a, lim_b, lo, hi;
  logic signed [17:0] v_off, v_sat, v_mir, v_fin;
  sjsc_pkg::cdeg_t    tgt_cmd, pose_c, p0, t0, step, p1, newp, newt, gap;

  sjsc_pkg::cdeg_t    pos, tgt;
  logic [25:0]        quot;

  always_comb begin
    mrad = present ? angle : 16'sd0;
    if (mrad > sjsc_pkg::MRAD_LIMIT) begin
      mrad = sjsc_pkg::MRAD_LIMIT;
    end else if (mrad < -sjsc_pkg::MRAD_LIMIT) begin
      mrad = -sjsc_pkg::MRAD_LIMIT;
    end
    span = 12'(mrad + sjsc_pkg::MRAD_LIMIT);
    prod = 35'(span) * 35'(sjsc_pkg::MAP_MULT);
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      mapped <= prod[sjsc_pkg::MAP_SHIFT +: 15];
    end
  end

  always_comb begin
    lim_a = (limits[15:0] > 16'(sjsc_pkg::FULL_SCALE)) ? sjsc_pkg::FULL_SCALE : limits[14:0];
    lim_b = (limits[30:16] > sjsc_pkg::FULL_SCALE) ? sjsc_pkg::FULL_SCALE : limits[30:16];
    lo = (lim_a > lim_b) ? lim_b : lim_a;
    hi = (lim_a > lim_b) ? lim_a : lim_b;

    v_off = signed'({3'b000, mapped}) + signed'({{2{offset[15]}}, offset});
    if (v_off < 18'sd0) begin
      v_sat = 18'sd0;
    end else if (v_off > signed'({3'b000, sjsc_pkg::FULL_SCALE})) begin
      v_sat = signed'({3'b000, sjsc_pkg::FULL_SCALE});
    end else begin
      v_sat = v_off;
    end
    v_mir = invert ? (signed'({3'b000, lo}) + signed'({3'b000, hi}) - v_sat) : v_sat;
    if (v_mir < signed'({3'b000, lo})) begin
      v_fin = signed'({3'b000, lo});
    end else if (v_mir > signed'({3'b000, hi})) begin
      v_fin = signed'({3'b000, hi});
    end else begin
      v_fin = v_mir;
    end
    tgt_cmd = v_fin[14:0];

    if (pose < lo) begin
      pose_c = lo;
    end else if (pose > hi) begin
      pose_c = hi;
    end else begin
      pose_c = pose;
    end

    p0 = ctl.pose_load ? pose_c : pos;
    t0 = ctl.pose_load ? pose_c : tgt;
    step = ctl.slow ? sjsc_pkg::SLOW_STEP : sjsc_pkg::NORMAL_STEP;

    if (p0 < t0) begin
      p1 = ((t0 - p0) <= step) ? t0 : p0 + step;
    end else if (p0 > t0) begin
      p1 = ((p0 - t0) <= step) ? t0 : p0 - step;
    end else begin
      p1 = p0;
    end

    newp = ctl.tick ? p1 : p0;
    newt = ctl.cmd_ok ? tgt_cmd : t0;
    gap = (newp >= newt) ? newp - newt : newt - newp;
    settle_next = (gap <= sjsc_pkg::SETTLE_TOL);
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      pos <= newp;
      tgt <= newt;
    end
  end

  assign quot  = 26'(pos[14:3]) * 26'(sjsc_pkg::DIV5_MULT);
  assign pulse = sjsc_pkg::PULSE_BASE + 10'(quot >> sjsc_pkg::DIV5_SHIFT);

endmodule

/* sv/sjsc_merge.sv */
// Merge stage: combines the lane settle flags and holds the mode and status bits.
// Depends on sjsc_pkg.
module sjsc_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  sjsc_pkg::lane_ctl_t         ctl,
  input  logic [sjsc_pkg::JOINTS-1:0] settle_next,
  output sjsc_pkg::merge_stat_t       stat
);

  logic slow, seen, loaded, all_settled, accepted;
  logic all_next;

  assign all_next = &settle_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow   <= 1'b1;
      seen   <= 1'b0;
      loaded <= 1'b0;
    end else if (ctl.s2_load) begin
      loaded <= 1'b1;
      seen   <= seen | ctl.cmd_ok;
      if (ctl.tick && slow && seen && all_next) begin
        slow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      all_settled <= all_next;
      accepted    <= ctl.cmd_ok;
    end
  end

  assign stat.slow        = slow;
  assign stat.all_settled = all_settled;
  assign stat.accepted    = accepted;
  assign stat.pose_loaded = loaded;

endmodule

/* sv/servo_joint_slew_controller_top.sv */
// Top level of the servo joint slew controller: configuration registers, the
// two-stage item pipeline, five joint lanes and the merge stage.
// Depends on sjsc_pkg, sjsc_lane and sjsc_merge.
//
// Usage. The input channel (cmd_valid, cmd_stall) carries one transaction per
// item: a joint command (operation 0) or an update tick (operation 1). The
// result channel (res_valid, res_stall) returns exactly one transaction per item
// with five pulse counts and the slow_mode, all_settled and command_accepted flags.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while idle, which the block itself does not enforce. Throughput
// is one item per cycle while the receiver does not stall. An item is taken into
// the mapping stage, where each lane's angle multiplier works; once the result
// register is free, the lanes update position and target and load the result
// register, which raises res_valid. Reset restores the register defaults, slow
// startup mode and the pending startup pose load; no clearing pass is needed.
// While the receiver stalls, the result holds, one further item waits in the
// mapping stage and cmd_stall rises after that.
module servo_joint_slew_controller_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic               operation,
  input  logic [2:0]         joint_count,
  input  logic signed [15:0] angle_0,
  input  logic signed [15:0] angle_1,
  input  logic signed [15:0] angle_2,
  input  logic signed [15:0] angle_3,
  input  logic signed [15:0] angle_4,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [9:0]         pulse_0,
  output logic [9:0]         pulse_1,
  output logic [9:0]         pulse_2,
  output logic [9:0]         pulse_3,
  output logic [9:0]         pulse_4,
  output logic               slow_mode,
  output logic               all_settled,
  output logic               command_accepted,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  logic [30:0]        limits [sjsc_pkg::JOINTS];
  logic [4:0]         invert_mask;
  logic signed [15:0] base_offset;

  logic s1_valid, s1_tick, s1_cmd_ok;
  logic s1_load, s2_load;

  sjsc_pkg::lane_ctl_t        ctl;
  sjsc_pkg::merge_stat_t      stat;
  logic [sjsc_pkg::JOINTS-1:0] settle_next;
  logic signed [15:0]          angles [sjsc_pkg::JOINTS];
  logic [9:0]                  pulses [sjsc_pkg::JOINTS];
  logic [2:0]                  joint_count_q;
  logic signed [15:0]          angles_q [sjsc_pkg::JOINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < sjsc_pkg::JOINTS; k++) begin
        limits[k] <= sjsc_pkg::LIMITS_RESET[k];
      end
      invert_mask <= sjsc_pkg::INVERT_RESET;
      base_offset <= sjsc_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index) inside
        [sjsc_pkg::REG_LIMITS0:sjsc_pkg::REG_LIMITS4]: begin
          limits[cfg_index] <= cfg_data;
        end
        sjsc_pkg::REG_INVERT: begin
          invert_mask <= cfg_data[4:0];
        end
        sjsc_pkg::REG_OFFSET: begin
          base_offset <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign s2_load   = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = s1_valid && !s2_load;
  assign s1_load   = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_tick   <= operation;
      s1_cmd_ok <= !operation && (joint_count >= 3'(sjsc_pkg::MIN_COMMAND_JOINTS));
    end
  end

  assign ctl.s1_load   = s1_load;
  assign ctl.s2_load   = s2_load;
  assign ctl.cmd_ok    = s1_cmd_ok;
  assign ctl.tick      = s1_tick;
  assign ctl.pose_load = !stat.pose_loaded;
  assign ctl.slow      = stat.slow;

  assign angles[0] = angle_0;
  assign angles[1] = angle_1;
  assign angles[2] = angle_2;
  assign angles[3] = angle_3;
  assign angles[4] = angle_4;

  for (genvar k = 0; k < sjsc_pkg::JOINTS; k++) begin : g_lane
    sjsc_lane u_lane (
      .clk         (clk),
      .ctl         (ctl),
      .present     (3'(k) < joint_count_q),
      .angle       (angles_q[k]),
      .limits      (limits[k]),
      .invert      (invert_mask[k]),
      .offset      ((k == 0) ? base_offset : 16'sd0),
      .pose        (sjsc_pkg::STARTUP_POSE[k]),
      .settle_next (settle_next[k]),
      .pulse       (pulses[k])
    );
  end

  // The lanes register the mapped angle at acceptance, so they see the input
  // fields of the transaction being taken.
  assign joint_count_q = joint_count;
  for (genvar k = 0; k < sjsc_pkg::JOINTS; k++) begin : g_angle
    assign angles_q[k] = angles[k];
  end

  sjsc_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .settle_next (settle_next),
    .stat        (stat)
  );

  assign pulse_0          = pulses[0];
  assign pulse_1          = pulses[1];
  assign pulse_2          = pulses[2];
  assign pulse_3          = pulses[3];
  assign pulse_4          = pulses[4];
  assign slow_mode        = stat.slow;
  assign all_settled      = stat.all_settled;
  assign command_accepted = stat.accepted;

  a_slow_never_returns: assert property (@(posedge clk) disable iff (rst)
    !stat.slow |=> !stat.slow)
    else $error("Slow mode came back after it had ended.");

  a_slow_ends_on_tick: assert property (@(posedge clk) disable iff (rst)
    $fell(stat.slow) |-> res_valid && !command_accepted)
    else $error("Slow mode ended on an item that was not a tick.");

  a_empty_pipe_takes: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !cmd_stall)
    else $error("Input stalled with an empty mapping stage.");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pulse_0 >= 10'd150 && pulse_0 <= 10'd600 &&
                  pulse_2 >= 10'd150 && pulse_2 <= 10'd600 &&
                  pulse_4 >= 10'd150 && pulse_4 <= 10'd600)
    else $error("Pulse count out of servo range.");

endmodule
